// ===== sv/kfmf_pkg.sv =====
// Shared types and constants for the first-match pattern finder.
// No dependencies; imported by kfmf_cell and kmp_first_match_finder.
package kfmf_pkg;

  localparam int unsigned PAT_BYTES  = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_W      = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned START_W    = 21;

  localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;

  typedef struct packed {
    logic step;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== sv/kfmf_cell.sv =====
// One matching cell: records whether the text so far ends in the pattern prefix
// whose last byte this cell compares. Depends on kfmf_pkg.
module kfmf_cell
  import kfmf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic              prev_flag_i,
  input  logic [BYTE_W-1:0] text_byte_i,
  input  logic [BYTE_W-1:0] pat_byte_i,
  output logic              hit_o,
  output logic              flag_o
);

  logic flag_q;
  logic flag_d;

  assign hit_o = prev_flag_i && (text_byte_i == pat_byte_i);

  always_comb begin
    flag_d = flag_q;
    if (ctrl_i.clear) begin
      flag_d = 1'b0;
    end else if (ctrl_i.step) begin
      flag_d = hit_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

  assign flag_o = flag_q;

endmodule

// ===== sv/kmp_first_match_finder.sv =====
// Top level of the first-match pattern finder: configuration registers,
// position count, result register and a row of kfmf_cell instances.
// Depends on kfmf_pkg and kfmf_cell.
//
// Usage: write the pattern bytes and length on the configuration port while
// no text is in flight. Text enters one item per byte on the input channel;
// the item with last_byte_i set ends the text. One result item follows each
// text: found_o and the 1-based start of the first match (0 if none).
// Each cell of the row holds one bit: whether the text so far ends in the
// pattern prefix of that cell's length. All cells update in the same cycle,
// so the block takes one byte per cycle while in_ready_o is high.
// The result is valid the cycle after the last byte is accepted.
// A result that the receiver has not taken holds the input channel off until
// it is taken, so a stall on the output costs input cycles only then.
// Reset clears the pattern to a single zero byte, the position count, the
// match record and the output register. Bytes past TEXT_MAX are counted as
// not present; a last flag on such a byte still yields the result.
module kmp_first_match_finder
  import kfmf_pkg::*;
#(
  parameter int unsigned     PATTERN_MAX = 16,
  parameter longint unsigned TEXT_MAX    = 64'd1048576
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [BYTE_W-1:0]    text_byte_i,
  input  logic                 last_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 found_o,
  output logic [START_W-1:0]   start_position_o
);

  localparam int unsigned POS_W = $clog2(TEXT_MAX + 64'd1);
  localparam int unsigned M_W   = $clog2(PATTERN_MAX + 1);

  logic [CFG_W-1:0] pat_low_q;
  logic [CFG_W-1:0] pat_high_q;
  logic [LEN_W-1:0] pat_len_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             seen_q, seen_d;
  logic [POS_W-1:0] start_q, start_d;
  logic             out_valid_q, out_valid_d;
  logic             found_q, found_d;
  logic [POS_W-1:0] out_start_q, out_start_d;

  logic             accept;
  logic             in_range;
  logic             cfg_hit;
  logic             found_now;
  logic [M_W-1:0]   m_eff;
  logic [POS_W-1:0] start_calc;
  cell_ctrl_t       ctrl;

  logic [PATTERN_MAX:0] flags;
  logic [PATTERN_MAX:1] hits;

  assign accept   = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_range = pos_q < POS_W'(TEXT_MAX);
  assign cfg_hit  = cfg_we_i && ((cfg_index_i == REG_PAT_LOW) ||
                    (cfg_index_i == REG_PAT_HIGH) || (cfg_index_i == REG_PAT_LEN));

  always_comb begin
    if (pat_len_q == '0) begin
      m_eff = M_W'(1);
    end else if (int'(pat_len_q) > int'(PATTERN_MAX)) begin
      m_eff = M_W'(PATTERN_MAX);
    end else begin
      m_eff = M_W'(pat_len_q);
    end
  end

  assign ctrl.step  = accept && in_range && !seen_q;
  assign found_now  = ctrl.step && hits[m_eff];
  assign ctrl.clear = cfg_hit || (accept && last_byte_i) || found_now;
  assign start_calc = pos_q + POS_W'(2) - POS_W'(m_eff);

  assign flags[0] = 1'b1;

  for (genvar k = 1; k <= PATTERN_MAX; k++) begin : g_cell
    logic [BYTE_W-1:0] pat_byte;
    if (k - 1 < 8) begin : g_low
      assign pat_byte = pat_low_q[BYTE_W*(k-1) +: BYTE_W];
    end else if (k - 1 < PAT_BYTES) begin : g_high
      assign pat_byte = pat_high_q[BYTE_W*(k-9) +: BYTE_W];
    end else begin : g_zero
      assign pat_byte = '0;
    end
    kfmf_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .prev_flag_i (flags[k-1]),
      .text_byte_i (text_byte_i),
      .pat_byte_i  (pat_byte),
      .hit_o       (hits[k]),
      .flag_o      (flags[k])
    );
  end

  always_comb begin
    pos_d       = pos_q;
    seen_d      = seen_q;
    start_d     = start_q;
    out_valid_d = out_valid_q;
    found_d     = found_q;
    out_start_d = out_start_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      if (in_range) begin
        pos_d = pos_q + POS_W'(1);
      end
      if (found_now) begin
        seen_d  = 1'b1;
        start_d = start_calc;
      end
      if (last_byte_i) begin
        out_valid_d = 1'b1;
        found_d     = seen_q || found_now;
        if (found_now) begin
          out_start_d = start_calc;
        end else if (seen_q) begin
          out_start_d = start_q;
        end else begin
          out_start_d = '0;
        end
        pos_d   = '0;
        seen_d  = 1'b0;
        start_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q   <= '0;
      pat_high_q  <= '0;
      pat_len_q   <= LEN_W'(1);
      pos_q       <= '0;
      seen_q      <= 1'b0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      out_start_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_PAT_LOW:  pat_low_q  <= cfg_data_i;
          REG_PAT_HIGH: pat_high_q <= cfg_data_i;
          REG_PAT_LEN:  pat_len_q  <= cfg_data_i[LEN_W-1:0];
          default: begin
          end
        endcase
      end
      pos_q       <= pos_d;
      seen_q      <= seen_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      out_start_q <= out_start_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign found_o          = found_q;
  assign start_position_o = START_W'(out_start_q);

  a_no_start_without_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> start_position_o == '0)
    else $error("start position set without a match");

  a_pos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(TEXT_MAX))
    else $error("position count beyond text limit");

  a_text_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_byte_i |=> pos_q == '0 && !seen_q && out_valid_o)
    else $error("text state not cleared after last byte");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_eff != '0 && int'(m_eff) <= int'(PATTERN_MAX))
    else $error("effective pattern length out of range");

  a_match_start_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_now |-> pos_q + POS_W'(1) >= POS_W'(m_eff))
    else $error("match reported before enough bytes");

endmodule
